### src/vmb_pkg.sv
// Package for the virtio-mmio block register window: register offsets,
// identity words, access codes and the structs passed between modules.
// No dependencies.
package vmb_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OffW    = 12;
  localparam int unsigned BitsW   = 7;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned FaultW  = 2;
  localparam int unsigned WdataW  = 64;
  localparam int unsigned DescW   = 64;

  // Access modes.
  localparam logic [ModeW-1:0] MODE_READ  = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd1;
  localparam logic [ModeW-1:0] MODE_POLL  = 2'd2;

  // Fault codes.
  localparam logic [FaultW-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FaultW-1:0] FAULT_LOAD  = 2'd1;
  localparam logic [FaultW-1:0] FAULT_STORE = 2'd2;

  // Only full-word accesses are allowed.
  localparam logic [BitsW-1:0] ACCESS_BITS_OK = 7'd32;

  // Register offsets in the device window.
  localparam logic [OffW-1:0] OFF_MAGIC       = 12'h000;
  localparam logic [OffW-1:0] OFF_VERSION     = 12'h004;
  localparam logic [OffW-1:0] OFF_DEVICE_ID   = 12'h008;
  localparam logic [OffW-1:0] OFF_VENDOR_ID   = 12'h00c;
  localparam logic [OffW-1:0] OFF_DEV_FEAT    = 12'h010;
  localparam logic [OffW-1:0] OFF_DRV_FEAT    = 12'h020;
  localparam logic [OffW-1:0] OFF_PAGE_SIZE   = 12'h028;
  localparam logic [OffW-1:0] OFF_RING_SELECT = 12'h030;
  localparam logic [OffW-1:0] OFF_QUEUE_MAX   = 12'h034;
  localparam logic [OffW-1:0] OFF_RING_SIZE   = 12'h038;
  localparam logic [OffW-1:0] OFF_RING_PAGE   = 12'h040;
  localparam logic [OffW-1:0] OFF_QUEUE_NOTIFY = 12'h050;
  localparam logic [OffW-1:0] OFF_STATUS      = 12'h070;

  // Fixed register contents.
  localparam logic [DataW-1:0] MAGIC_VALUE    = 32'h7472_6976;
  localparam logic [DataW-1:0] VERSION_VALUE  = 32'h0000_0001;
  localparam logic [DataW-1:0] DEVICE_ID_VAL  = 32'h0000_0002;
  localparam logic [DataW-1:0] VENDOR_ID_VAL  = 32'h554d_4551;
  localparam logic [DataW-1:0] QUEUE_MAX_VAL  = 32'd8;
  localparam logic [DataW-1:0] NOTHING_PENDING = 32'd9999;

  // One registered transaction as seen by the register file.
  typedef struct packed {
    logic              valid;
    logic [ModeW-1:0]  mode;
    logic [OffW-1:0]   offset;
    logic [BitsW-1:0]  access_bits;
    logic [DataW-1:0]  wdata;
  } vmb_item_t;

  // Decoded result plus the post-update operands of the base product.
  typedef struct packed {
    logic              valid;
    logic [DataW-1:0]  read_data;
    logic [FaultW-1:0] fault;
    logic              irq;
    logic [DataW-1:0]  page_number;
    logic [DataW-1:0]  page_bytes;
  } vmb_res_t;

endpackage

### src/vmb_regs.sv
// Register file and access decode of the virtio-mmio block window.
// Depends on vmb_pkg.
module vmb_regs
  import vmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  vmb_item_t item,
  output vmb_res_t  res
);

  logic [DataW-1:0] drv_feat_r,  drv_feat_nxt;
  logic [DataW-1:0] page_size_r, page_size_nxt;
  logic [DataW-1:0] ring_idx_r,  ring_idx_nxt;
  logic [DataW-1:0] ring_len_r,  ring_len_nxt;
  logic [DataW-1:0] ring_page_r, ring_page_nxt;
  logic [DataW-1:0] notify_r,    notify_nxt;
  logic [DataW-1:0] status_r,    status_nxt;

  logic             size_ok;
  logic             do_write;
  logic [DataW-1:0] rd_val;

  assign size_ok  = (item.access_bits == ACCESS_BITS_OK);
  assign do_write = item.valid && (item.mode == MODE_WRITE) && size_ok;

  always_comb begin
    case (item.offset)
      OFF_MAGIC:     rd_val = MAGIC_VALUE;
      OFF_VERSION:   rd_val = VERSION_VALUE;
      OFF_DEVICE_ID: rd_val = DEVICE_ID_VAL;
      OFF_VENDOR_ID: rd_val = VENDOR_ID_VAL;
      OFF_DRV_FEAT:  rd_val = drv_feat_r;
      OFF_QUEUE_MAX: rd_val = QUEUE_MAX_VAL;
      OFF_RING_PAGE: rd_val = ring_page_r;
      OFF_STATUS:    rd_val = status_r;
      default:       rd_val = '0;
    endcase
  end

  always_comb begin
    drv_feat_nxt  = drv_feat_r;
    page_size_nxt = page_size_r;
    ring_idx_nxt  = ring_idx_r;
    ring_len_nxt  = ring_len_r;
    ring_page_nxt = ring_page_r;
    notify_nxt    = notify_r;
    status_nxt    = status_r;

    res.valid       = item.valid;
    res.read_data   = '0;
    res.fault       = FAULT_NONE;
    res.irq         = 1'b0;

    if (do_write) begin
      case (item.offset)
        OFF_DRV_FEAT:     drv_feat_nxt  = item.wdata;
        OFF_PAGE_SIZE:    page_size_nxt = item.wdata;
        OFF_RING_SELECT:  ring_idx_nxt  = item.wdata;
        OFF_RING_SIZE:    ring_len_nxt  = item.wdata;
        OFF_RING_PAGE:    ring_page_nxt = item.wdata;
        OFF_QUEUE_NOTIFY: notify_nxt    = item.wdata;
        OFF_STATUS:       status_nxt    = item.wdata;
        default:          ;
      endcase
    end

    if (item.valid) begin
      case (item.mode)
        MODE_READ: begin
          if (size_ok) begin
            res.read_data = rd_val;
          end else begin
            res.fault = FAULT_LOAD;
          end
        end
        MODE_WRITE: begin
          if (!size_ok) begin
            res.fault = FAULT_STORE;
          end
        end
        MODE_POLL: begin
          // A poll consumes a pending notify.
          if (notify_r != NOTHING_PENDING) begin
            notify_nxt = NOTHING_PENDING;
            res.irq    = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // The descriptor base is taken from the state after this transaction.
    res.page_number = ring_page_nxt;
    res.page_bytes  = page_size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_feat_r  <= '0;
      page_size_r <= '0;
      ring_idx_r  <= '0;
      ring_len_r  <= '0;
      ring_page_r <= '0;
      notify_r    <= NOTHING_PENDING;
      status_r    <= '0;
    end else begin
      drv_feat_r  <= drv_feat_nxt;
      page_size_r <= page_size_nxt;
      ring_idx_r  <= ring_idx_nxt;
      ring_len_r  <= ring_len_nxt;
      ring_page_r <= ring_page_nxt;
      notify_r    <= notify_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

### src/vmb_result.sv
// Result stage: descriptor base multiply and the output register.
// Depends on vmb_pkg.
module vmb_result
  import vmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  vmb_res_t          res,
  output logic              out_valid,
  output logic [DataW-1:0]  out_read_data,
  output logic [FaultW-1:0] out_fault,
  output logic              out_irq,
  output logic [DescW-1:0]  out_desc_base
);

  logic              valid_r;
  logic [DataW-1:0]  read_data_r;
  logic [FaultW-1:0] fault_r;
  logic              irq_r;
  logic [DescW-1:0]  desc_base_r, desc_base_nxt;

  assign desc_base_nxt = DescW'(res.page_number) * DescW'(res.page_bytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    read_data_r <= res.read_data;
    fault_r     <= res.fault;
    irq_r       <= res.irq;
    desc_base_r <= desc_base_nxt;
  end

  assign out_valid     = valid_r;
  assign out_read_data = read_data_r;
  assign out_fault     = fault_r;
  assign out_irq       = irq_r;
  assign out_desc_base = desc_base_r;

endmodule

### src/virtio_mmio_block_registers_unit.sv
// Top level of the legacy virtio-mmio block device register window.
// Depends on vmb_pkg, vmb_regs and vmb_result.
//
//  channel   handshake             payload
//  input     start (busy is low)   in_mode, in_offset, in_access_bits, in_write_data
//  result    out_valid strobe      out_read_data, out_fault, out_irq, out_desc_base
//
// A transaction is registered on acceptance, decoded against the register
// file from that register and its result is registered again for the outputs;
// one transaction can be taken every cycle.
// busy is always low. The result stage cannot be stalled by the receiver.
// Reset returns the register file to zero and the notify to its idle value.
module virtio_mmio_block_registers_unit
  import vmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ModeW-1:0]  in_mode,
  input  logic [OffW-1:0]   in_offset,
  input  logic [BitsW-1:0]  in_access_bits,
  input  logic [WdataW-1:0] in_write_data,
  output logic              out_valid,
  output logic [DataW-1:0]  out_read_data,
  output logic [FaultW-1:0] out_fault,
  output logic              out_irq,
  output logic [DescW-1:0]  out_desc_base
);

  vmb_item_t item_r;
  vmb_res_t  res;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Only the low word of the write data is ever stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= accept;
    end
    item_r.mode        <= in_mode;
    item_r.offset      <= in_offset;
    item_r.access_bits <= in_access_bits;
    item_r.wdata       <= in_write_data[DataW-1:0];
  end

  vmb_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .res   (res)
  );

  vmb_result u_result (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_fault     (out_fault),
    .out_irq       (out_irq),
    .out_desc_base (out_desc_base)
  );

endmodule

### src/vmb_checker.sv
// Port-level checks for the virtio-mmio block register window, bound to
// the top level. Depends on vmb_pkg.
module vmb_checker
  import vmb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [DataW-1:0]  out_read_data,
  input logic [FaultW-1:0] out_fault,
  input logic              out_irq
);

  // Every accepted transaction yields its result after the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 2))
    else $error("result without an accepted transaction");

  // A faulted access returns no data and no interrupt.
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault != FAULT_NONE)) |-> (out_read_data == '0 && !out_irq))
    else $error("faulted access returned data or interrupt");

  // An interrupt only comes from a poll, which never reads data.
  a_irq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq) |-> (out_fault == FAULT_NONE && out_read_data == '0))
    else $error("interrupt result carried data or fault");

endmodule

bind virtio_mmio_block_registers_unit vmb_checker u_vmb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_read_data (out_read_data),
  .out_fault     (out_fault),
  .out_irq       (out_irq)
);

### dv/tb_virtio_mmio_block_registers_unit.sv
`timescale 1ns / 1ps
// Testbench for virtio_mmio_block_registers_unit: directed and random register transactions,
// with every result checked against a register window model kept in the bench.
// Depends on vmb_pkg and the RTL of the unit.
module tb_virtio_mmio_block_registers_unit;
  import vmb_pkg::*;

  localparam int unsigned IdleLimit      = 500;
  localparam int unsigned RandomItems    = 1925;
  localparam int unsigned DrainEvery     = 450;
  localparam int unsigned MaxErrorPrints = 40;
  // Mode code with no defined operation.
  localparam logic [ModeW-1:0] ModeNone  = 2'd3;

  typedef struct {
    logic [ModeW-1:0]  mode;
    logic [OffW-1:0]   offset;
    logic [BitsW-1:0]  bits;
    logic [WdataW-1:0] wdata;
    bit                drain;
  } access_t;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic [FaultW-1:0] fault;
    logic              irq;
    logic [DescW-1:0]  desc_base;
  } reg_result_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic [ModeW-1:0]  in_mode        = MODE_READ;
  logic [OffW-1:0]   in_offset      = '0;
  logic [BitsW-1:0]  in_access_bits = '0;
  logic [WdataW-1:0] in_write_data  = '0;
  logic              busy;
  logic              out_valid;
  logic [DataW-1:0]  out_read_data;
  logic [FaultW-1:0] out_fault;
  logic              out_irq;
  logic [DescW-1:0]  out_desc_base;

  virtio_mmio_block_registers_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_offset     (in_offset),
    .in_access_bits(in_access_bits),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_fault     (out_fault),
    .out_irq       (out_irq),
    .out_desc_base (out_desc_base)
  );

  always #5 clk = ~clk;

  access_t     access_q[$];
  reg_result_t reg_results_q[$];

  // Register window model.
  logic [DataW-1:0] drv_features = '0;
  logic [DataW-1:0] page_bytes   = '0;
  logic [DataW-1:0] ring_idx     = '0;
  logic [DataW-1:0] ring_len     = '0;
  logic [DataW-1:0] ring_page    = '0;
  logic [DataW-1:0] notify_val   = NOTHING_PENDING;
  logic [DataW-1:0] dev_status   = '0;

  logic        took        = 1'b0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left    = 0;
  int unsigned burst_left  = 0;

  logic [OffW-1:0] listed_offs[13] = '{OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID,
                                       OFF_DEV_FEAT, OFF_DRV_FEAT, OFF_PAGE_SIZE, OFF_RING_SELECT,
                                       OFF_QUEUE_MAX, OFF_RING_SIZE, OFF_RING_PAGE,
                                       OFF_QUEUE_NOTIFY, OFF_STATUS};

  // Applies one transaction to the model and returns the result the unit should give.
  function automatic reg_result_t decode_access(input logic [ModeW-1:0] mode,
                                                input logic [OffW-1:0] offset,
                                                input logic [BitsW-1:0] bits,
                                                input logic [WdataW-1:0] wdata);
    reg_result_t r;
    r = '0;
    case (mode)
      MODE_READ: begin
        if (bits != ACCESS_BITS_OK) begin
          r.fault = FAULT_LOAD;
        end else begin
          case (offset)
            OFF_MAGIC:     r.read_data = MAGIC_VALUE;
            OFF_VERSION:   r.read_data = VERSION_VALUE;
            OFF_DEVICE_ID: r.read_data = DEVICE_ID_VAL;
            OFF_VENDOR_ID: r.read_data = VENDOR_ID_VAL;
            OFF_DRV_FEAT:  r.read_data = drv_features;
            OFF_QUEUE_MAX: r.read_data = QUEUE_MAX_VAL;
            OFF_RING_PAGE: r.read_data = ring_page;
            OFF_STATUS:    r.read_data = dev_status;
            default:       r.read_data = '0;
          endcase
        end
      end
      MODE_WRITE: begin
        if (bits != ACCESS_BITS_OK) begin
          r.fault = FAULT_STORE;
        end else begin
          case (offset)
            OFF_DRV_FEAT:     drv_features = wdata[DataW-1:0];
            OFF_PAGE_SIZE:    page_bytes   = wdata[DataW-1:0];
            OFF_RING_SELECT:  ring_idx     = wdata[DataW-1:0];
            OFF_RING_SIZE:    ring_len     = wdata[DataW-1:0];
            OFF_RING_PAGE:    ring_page    = wdata[DataW-1:0];
            OFF_QUEUE_NOTIFY: notify_val   = wdata[DataW-1:0];
            OFF_STATUS:       dev_status   = wdata[DataW-1:0];
            default: ;
          endcase
        end
      end
      MODE_POLL: begin
        if (notify_val != NOTHING_PENDING) begin
          notify_val = NOTHING_PENDING;
          r.irq = 1'b1;
        end
      end
      default: ;
    endcase
    r.desc_base = DescW'(ring_page) * DescW'(page_bytes);
    return r;
  endfunction

  function automatic void add_access(input logic [ModeW-1:0] mode, input logic [OffW-1:0] offset,
                                     input logic [BitsW-1:0] bits, input logic [WdataW-1:0] wdata,
                                     input bit drain = 1'b0);
    access_t a;
    a.mode   = mode;
    a.offset = offset;
    a.bits   = bits;
    a.wdata  = wdata;
    a.drain  = drain;
    access_q.push_back(a);
  endfunction

  // Mostly random words, with the extremes and the idle notify value mixed in.
  function automatic logic [WdataW-1:0] rand_data();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 16) return '1;
    if (sel < 22) return {$urandom, NOTHING_PENDING};
    if (sel < 40) return {$urandom, 32'($urandom_range(0, 255))};
    return {$urandom, $urandom};
  endfunction

  // Gap after a transaction: mostly none or short, sometimes long, with bursts of none.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Driver: presents the next transaction once the current one is taken and its gap is over.
  always @(negedge clk) begin : driver
    access_t item;
    bit      sending;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      sending = start && !took;
      if (!sending) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() > 0 &&
                     !(access_q[0].drain && reg_results_q.size() > 0)) begin
          item = access_q.pop_front();
          in_mode        <= item.mode;
          in_offset      <= item.offset;
          in_access_bits <= item.bits;
          in_write_data  <= item.wdata;
          sending  = 1'b1;
          gap_left = pick_gap();
        end
      end
      start <= sending;
    end
  end

  // Monitor: predicts on acceptance, checks each result strobe, and runs the watchdog.
  always @(posedge clk) begin : monitor
    reg_result_t got;
    reg_result_t want;
    if (!rst_n) begin
      took         <= 1'b0;
      drv_features = '0;
      page_bytes   = '0;
      ring_idx     = '0;
      ring_len     = '0;
      ring_page    = '0;
      notify_val   = NOTHING_PENDING;
      dev_status   = '0;
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        reg_results_q.push_back(decode_access(in_mode, in_offset, in_access_bits,
                                              in_write_data));
      end
      if (out_valid) begin
        got = {out_read_data, out_fault, out_irq, out_desc_base};
        if (reg_results_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxErrorPrints) begin
            $display("%0t: result with none expected: read_data %h fault %0d irq %0d desc %h",
                     $time, got.read_data, got.fault, got.irq, got.desc_base);
          end
        end else begin
          want = reg_results_q.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= MaxErrorPrints) begin
              $display("%0t: mismatch: expected read_data %h fault %0d irq %0d desc %h",
                       $time, want.read_data, want.fault, want.irq, want.desc_base);
              $display("%0t:           actual read_data %h fault %0d irq %0d desc %h",
                       $time, got.read_data, got.fault, got.irq, got.desc_base);
            end
          end
        end
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("tb_virtio_mmio_block_registers_unit: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sel;
    logic [ModeW-1:0] mode;

    // Identity words and the fixed reads.
    add_access(MODE_READ, OFF_MAGIC, ACCESS_BITS_OK, '0);
    add_access(MODE_READ, OFF_VERSION, ACCESS_BITS_OK, '0);
    add_access(MODE_READ, OFF_DEVICE_ID, ACCESS_BITS_OK, '0);
    add_access(MODE_READ, OFF_VENDOR_ID, ACCESS_BITS_OK, '0);
    add_access(MODE_READ, OFF_QUEUE_MAX, ACCESS_BITS_OK, '0);
    // Device features are read-only and must stay zero after a write.
    add_access(MODE_WRITE, OFF_DEV_FEAT, ACCESS_BITS_OK, '1);
    add_access(MODE_READ, OFF_DEV_FEAT, ACCESS_BITS_OK, '0);
    // Upper half of the write value is dropped.
    add_access(MODE_WRITE, OFF_DRV_FEAT, ACCESS_BITS_OK, '1);
    add_access(MODE_READ, OFF_DRV_FEAT, ACCESS_BITS_OK, '0);
    // Largest descriptor base, then the write-only page size reads back as zero.
    add_access(MODE_WRITE, OFF_PAGE_SIZE, ACCESS_BITS_OK, '1);
    add_access(MODE_WRITE, OFF_RING_PAGE, ACCESS_BITS_OK, '1);
    add_access(MODE_READ, OFF_RING_PAGE, ACCESS_BITS_OK, '0);
    add_access(MODE_READ, OFF_PAGE_SIZE, ACCESS_BITS_OK, '0);
    add_access(MODE_WRITE, OFF_RING_SELECT, ACCESS_BITS_OK, 64'hdead_beef_0000_0003);
    add_access(MODE_WRITE, OFF_STATUS, ACCESS_BITS_OK, 64'h0123_4567_89ab_cdef);
    add_access(MODE_READ, OFF_STATUS, ACCESS_BITS_OK, '0);
    // A notify of zero is pending; the poll ignores its other fields.
    add_access(MODE_WRITE, OFF_QUEUE_NOTIFY, ACCESS_BITS_OK, '0);
    add_access(MODE_POLL, '1, '1, '1);
    add_access(MODE_POLL, OFF_QUEUE_NOTIFY, ACCESS_BITS_OK, '0);
    // Writing the idle value means nothing is pending.
    add_access(MODE_WRITE, OFF_QUEUE_NOTIFY, ACCESS_BITS_OK, 64'(NOTHING_PENDING));
    add_access(MODE_POLL, '0, '0, '0);
    // Wrong sizes fault and leave the features alone.
    add_access(MODE_READ, OFF_DRV_FEAT, 7'd64, '0);
    add_access(MODE_WRITE, OFF_DRV_FEAT, '0, '0);
    add_access(MODE_READ, OFF_DRV_FEAT, ACCESS_BITS_OK, '0);
    add_access(MODE_READ, '1, ACCESS_BITS_OK, '0);
    add_access(ModeNone, OFF_RING_PAGE, ACCESS_BITS_OK, '1);
    // The sender waits here until every earlier result has come back.
    add_access(MODE_READ, OFF_MAGIC, ACCESS_BITS_OK, '0, 1'b1);

    for (int i = 0; i < RandomItems; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        sel  = $urandom_range(0, 99);
        mode = (sel < 45) ? MODE_READ : (sel < 92) ? MODE_WRITE : MODE_POLL;
        add_access(mode, listed_offs[$urandom_range(0, 12)], ACCESS_BITS_OK, rand_data(),
                   (i % DrainEvery) == 0);
      end else if (sel < 82) begin
        add_access(MODE_WRITE, OFF_QUEUE_NOTIFY, ACCESS_BITS_OK, rand_data());
        add_access(MODE_POLL, OffW'($urandom), BitsW'($urandom), {$urandom, $urandom});
        i++;
      end else if (sel < 90) begin
        mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
        add_access(mode, listed_offs[$urandom_range(0, 12)], BitsW'($urandom), rand_data());
      end else begin
        add_access(ModeW'($urandom), OffW'($urandom), BitsW'($urandom), {$urandom, $urandom});
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (access_q.size() > 0 || start || reg_results_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0 && reg_results_q.size() == 0) begin
      $display("tb_virtio_mmio_block_registers_unit: done, clean");
    end else begin
      $display("tb_virtio_mmio_block_registers_unit: done, errors");
    end
    $finish;
  end

endmodule

### virtio_mmio_block_registers_unit.f
src/vmb_pkg.sv
src/vmb_regs.sv
src/vmb_result.sv
src/virtio_mmio_block_registers_unit.sv
src/vmb_checker.sv
dv/tb_virtio_mmio_block_registers_unit.sv
